// File: sv/cfws_pkg.sv
`timescale 1ns / 1ps

package cfws_pkg;

  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;
  localparam int FREE_W = 7;

  localparam int CAP_RESET = 64;
  localparam logic [CNT_W-1:0] MAX_BURST = 7'd64;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BURST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd3;

  localparam logic [1:0] OUT_ACK  = 2'd0;
  localparam logic [1:0] OUT_FULL = 2'd1;
  localparam logic [1:0] OUT_FAIL = 2'd2;
  localparam logic [1:0] OUT_POP  = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       do_push;
    logic       pop_first;
    logic       pop_next;
    logic       scan_start;
    logic       scan_next;
    logic       hit_upd;
    logic       out_ld;
    logic [1:0] out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              refuse;
    logic              match;
    logic              scan_last;
    logic              remain_zero;
    logic              out_free;
  } dp_stat_t;

endpackage

// File: sv/cfws_if.sv
`timescale 1ns / 1ps

interface cfws_in_if;
  import cfws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] data_value;
  logic [CNT_W-1:0]         pop_count;

  modport source (output valid, output mode, output data_value, output pop_count,
                  input ready);
  modport sink (input valid, input mode, input data_value, input pop_count,
                output ready);
endinterface

interface cfws_out_if;
  import cfws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic                     success;
  logic                     found;
  logic                     last;
  logic [FREE_W-1:0]        free_space;

  modport source (output valid, output data_out, output success, output found,
                  output last, output free_space, input ready);
  modport sink (input valid, input data_out, input success, input found,
                input last, input free_space, output ready);
endinterface

// File: sv/cfws_ram.sv
`timescale 1ns / 1ps

module cfws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cfws_dp.sv
`timescale 1ns / 1ps

module cfws_dp #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfws_pkg::ctrl_cmd_t               cmd,
  output cfws_pkg::dp_stat_t                stat,
  input  logic [cfws_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [cfws_pkg::DATA_W-1:0] in_data_value,
  input  logic [cfws_pkg::CNT_W-1:0]        in_pop_count,
  input  logic                              cfg_we,
  input  logic [cfws_pkg::CAP_W-1:0]        cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [cfws_pkg::DATA_W-1:0] out_data_out,
  output logic                              out_success,
  output logic                              out_found,
  output logic                              out_last,
  output logic [cfws_pkg::FREE_W-1:0]       out_free_space
);
  import cfws_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CAP_RST = CW'((CAP_RESET > DEPTH) ? DEPTH : CAP_RESET);

  logic [MODE_W-1:0]        mode_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         n_r;
  logic [CW-1:0]            cap_r;
  logic [CW-1:0]            cfg_cap;
  logic [AW-1:0]            rp_r;
  logic [AW-1:0]            wp_r;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            cnt_nxt;
  logic [CNT_W-1:0]         remain_r;
  logic [AW-1:0]            scan_addr_r;
  logic [CW-1:0]            scan_i_r;
  logic                     hit_r;
  logic                     pop_rd;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] data_out_r;
  logic signed [DATA_W-1:0] data_out_nxt;
  logic                     success_r;
  logic                     success_nxt;
  logic                     found_r;
  logic                     found_nxt;
  logic                     last_r;
  logic                     last_nxt;
  logic [FREE_W-1:0]        free_r;
  logic [FREE_W-1:0]        free_nxt;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] c);
    adv = ((CW'(p) + CW'(1)) == c) ? '0 : p + AW'(1);
  endfunction

  assign cfg_cap = ((cfg_data == '0) || (32'(cfg_data) > 32'(DEPTH))) ?
                   CW'(DEPTH) : CW'(cfg_data);

  assign pop_rd    = cmd.pop_first | cmd.pop_next;
  assign ram_re    = pop_rd | cmd.scan_start | cmd.scan_next;
  assign ram_raddr = cmd.scan_next ? scan_addr_r : rp_r;

  cfws_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.do_push),
    .waddr (wp_r),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.do_push) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_rd) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    data_out_nxt = '0;
    success_nxt  = 1'b0;
    found_nxt    = 1'b0;
    last_nxt     = 1'b1;
    free_nxt     = FREE_W'(cap_r - cnt_nxt);
    case (cmd.out_kind)
      OUT_ACK: begin
        success_nxt = 1'b1;
        found_nxt   = hit_r;
      end
      OUT_FULL: begin
        success_nxt = 1'b0;
      end
      OUT_FAIL: begin
        data_out_nxt = {DATA_W{1'b1}};
      end
      OUT_POP: begin
        data_out_nxt = ram_rdata;
        success_nxt  = 1'b1;
        last_nxt     = (remain_r == '0);
        free_nxt     = FREE_W'(cap_r - cnt_r);
      end
      default: begin
        success_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RST;
      rp_r        <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_cap;
        rp_r  <= '0;
        wp_r  <= '0;
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        if (cmd.do_push) begin
          wp_r <= adv(wp_r, cap_r);
        end
        if (pop_rd) begin
          rp_r <= adv(rp_r, cap_r);
        end
      end
      if (cmd.latch) begin
        hit_r <= 1'b0;
      end else if (cmd.hit_upd) begin
        hit_r <= stat.match;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      val_r  <= in_data_value;
      n_r    <= in_pop_count;
    end
    if (cmd.pop_first) begin
      remain_r <= (mode_r == MODE_BURST) ? n_r - CNT_W'(1) : '0;
    end else if (cmd.pop_next) begin
      remain_r <= remain_r - CNT_W'(1);
    end
    if (cmd.scan_start) begin
      scan_addr_r <= adv(rp_r, cap_r);
      scan_i_r    <= '0;
    end else if (cmd.scan_next) begin
      scan_addr_r <= adv(scan_addr_r, cap_r);
      scan_i_r    <= scan_i_r + CW'(1);
    end
    if (cmd.out_ld) begin
      data_out_r <= data_out_nxt;
      success_r  <= success_nxt;
      found_r    <= found_nxt;
      last_r     <= last_nxt;
      free_r     <= free_nxt;
    end
  end

  assign stat.mode        = mode_r;
  assign stat.full        = (cnt_r == cap_r);
  assign stat.empty       = (cnt_r == '0);
  assign stat.refuse      = (n_r == '0) || (n_r > MAX_BURST) || (32'(n_r) > 32'(cnt_r));
  assign stat.match       = (ram_rdata == val_r);
  assign stat.scan_last   = ((scan_i_r + CW'(1)) == cnt_r);
  assign stat.remain_zero = (remain_r == '0);
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_data_out   = data_out_r;
  assign out_success    = success_r;
  assign out_found      = found_r;
  assign out_last       = last_r;
  assign out_free_space = free_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap_r)
    else $error("stored count above capacity");

  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push |-> (cnt_r != cap_r))
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop_rd |-> (cnt_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

// File: sv/cfws_ctrl.sv
`timescale 1ns / 1ps

module cfws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfws_pkg::dp_stat_t  stat,
  output cfws_pkg::ctrl_cmd_t cmd
);
  import cfws_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.mode)
          MODE_PUSH: begin
            if (stat.out_free) begin
              cmd.out_ld   = 1'b1;
              cmd.out_kind = stat.full ? OUT_FULL : OUT_ACK;
              cmd.do_push  = !stat.full;
              state_nxt    = S_IDLE;
            end
          end
          MODE_POP, MODE_BURST: begin
            if (stat.empty || (stat.mode == MODE_BURST && stat.refuse)) begin
              if (stat.out_free) begin
                cmd.out_ld   = 1'b1;
                cmd.out_kind = OUT_FAIL;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.pop_first = 1'b1;
              state_nxt     = S_POP;
            end
          end
          default: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_ld   = 1'b1;
                cmd.out_kind = OUT_ACK;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SRCH;
            end
          end
        endcase
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = OUT_POP;
          if (stat.remain_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pop_next = 1'b1;
          end
        end
      end
      S_SRCH: begin
        if (stat.match || stat.scan_last) begin
          cmd.hit_upd = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_kind = OUT_ACK;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: sv/circular_fifo_with_search_top.sv
// circular FIFO of signed 32-bit words with push, pop, burst pop and search
// in_ch carries one request beat per item (mode, data_value, pop_count);
// out_ch carries result beats (data_out, success, found, last, free_space).
// cfg_we/cfg_data write the capacity; a write empties the queue. capacity 0
// or above DEPTH means DEPTH. write it only while no item is in flight.
// one item is worked on at a time; entries sit in a RAM with one write port
// and one registered read port, and that read port paces pops and searches:
//   push: the result is loaded from the decode state that follows the input beat
//   pop one, burst of n: first read in decode, then one result per cycle while out_ch does not stall
//   search: reads from the head on until a hit or the last stored entry,
//   then loads one result; empty pop, refused burst: one fail result from decode
// every item ends with a beat marked last; an accepted burst gives n beats.
// results sit in an output register, so the next input beat is taken while
// a result waits; a stall on out_ch holds the result and the work behind it.
// reset (rst_n low, synchronous) empties the queue and sets capacity to 64 (DEPTH if smaller).
`timescale 1ns / 1ps

module circular_fifo_with_search_top #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cfws_in_if.sink                    in_ch,
  cfws_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [cfws_pkg::CAP_W-1:0] cfg_data
);
  import cfws_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  cfws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_mode        (in_ch.mode),
    .in_data_value  (in_ch.data_value),
    .in_pop_count   (in_ch.pop_count),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_data_out   (out_ch.data_out),
    .out_success    (out_ch.success),
    .out_found      (out_ch.found),
    .out_last       (out_ch.last),
    .out_free_space (out_ch.free_space)
  );

endmodule
